FILE: rtl/pfc_pkg.sv
// Shared types, constants and the byte-wide CRC-24 update for the packet framer.
// No dependencies; imported by pfc_crc_unit and packet_framer_crc24.
package pfc_pkg;

    localparam logic [23:0] CRC_POLY  = 24'h00065B;
    localparam logic [23:0] CRC_RESET = 24'h555555;

    // Position of the byte being emitted within one framing job
    typedef enum logic [2:0] {
        STEP_PREAMBLE = 3'd0,
        STEP_SOURCE   = 3'd1,
        STEP_DEST     = 3'd2,
        STEP_HEADER   = 3'd3,
        STEP_LEN      = 3'd4,   // length byte on a start job, payload byte otherwise
        STEP_CRC_HI   = 3'd5,
        STEP_CRC_MID  = 3'd6,
        STEP_CRC_LO   = 3'd7
    } step_t;

    typedef struct packed {
        logic feed;      // shift one byte into the CRC this cycle
        logic load;      // start from the preset instead of the running value
    } crc_ctl_t;

    // Shift one byte into the CRC, most significant bit first
    function automatic logic [23:0] crc24_byte(input logic [23:0] crc_in,
                                               input logic [7:0]  data);
        logic [23:0] c;
        logic        fb;
        c = crc_in;
        for (int k = 7; k >= 0; k--) begin
            fb = c[23] ^ data[k];
            c  = {c[22:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/pfc_crc_unit.sv
// Running CRC-24 register with a byte-wide update per cycle while ctl.feed is high.
// Depends on pfc_pkg (crc24_byte, crc_ctl_t, CRC_RESET).
module pfc_crc_unit
    import pfc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  crc_ctl_t    ctl,
    input  logic [7:0]  data,
    input  logic [23:0] preset,
    output logic [23:0] crc
);

    logic [23:0] crc_reg;
    logic [23:0] crc_next;
    logic [23:0] crc_base;

    assign crc_base = ctl.load ? preset : crc_reg;
    assign crc_next = ctl.feed ? crc24_byte(crc_base, data) : crc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_RESET;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

FILE: rtl/packet_framer_crc24.sv
// Top level of the packet framer: input job register, byte sequencer, output register.
// Depends on pfc_pkg and pfc_crc_unit.
//
// Usage:
//   The slave channel takes transactions of two kinds, chosen by s_tuser: a start
//   transaction (s_tuser = 0) opens a packet with source, destination, header and
//   payload length; a payload transaction (s_tuser = 1) carries one payload byte.
//   The master channel sends the framed packet one byte per transaction: preamble,
//   source, destination, header, length, payload bytes, then the CRC-24 most
//   significant byte first. m_tlast marks the final CRC byte.
//   Path: an accepted transaction goes to the job register, then each of its
//   bytes to the output register, from which the master channel presents it.
//   Bytes: a payload transaction yields one byte, the final payload transaction
//   of a packet four (byte plus three CRC bytes), a start transaction five bytes
//   and eight with an empty payload. The master channel moves one byte per cycle
//   while m_tready stays high; the CRC register absorbs each head and payload byte.
//   A payload transaction outside an open packet is accepted and dropped.
//   Reset: synchronous, aresetn low. Clears the packet state, both output and job
//   valids, and returns preamble_value to 0 and crc_preset to 0x555555.
//   Stall: with the output register full and m_tready low, both it and the job
//   register hold; s_tready is high only with no job or as its last byte is emitted.
//   Configuration writes are taken on any cycle with cfg_wr_en high and affect
//   the next packet; write them only while the framer is idle.
module packet_framer_crc24
    import pfc_pkg::*;
#(
    parameter int MAX_PAYLOAD = 255
)(
    input  logic        aclk,
    input  logic        aresetn,
    // slave channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] source_addr, [15:8] dest_addr,
                                   // [23:16] header_byte, [31:24] payload_len,
                                   // [39:32] payload_byte
    input  logic        s_tuser,   // [0] req_type: 0 start, 1 payload
    // master channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // last CRC byte of the packet
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [23:0] cfg_wdata
);

    localparam logic       CFG_PREAMBLE = 1'b0;
    localparam logic       CFG_PRESET   = 1'b1;
    localparam logic [7:0] MAX_LEN      = 8'(MAX_PAYLOAD);

    // Split the slave payload
    logic [7:0] in_src;
    logic [7:0] in_dst;
    logic [7:0] in_hdr;
    logic [7:0] in_len;
    logic [7:0] in_pay;
    logic [7:0] len_clamped;

    assign in_src = s_tdata[7:0];
    assign in_dst = s_tdata[15:8];
    assign in_hdr = s_tdata[23:16];
    assign in_len = s_tdata[31:24];
    assign in_pay = s_tdata[39:32];
    assign len_clamped = (in_len > MAX_LEN) ? MAX_LEN : in_len;

    // Configuration registers
    logic [7:0]  preamble_reg;
    logic [23:0] preset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preamble_reg <= 8'd0;
            preset_reg   <= CRC_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PREAMBLE: preamble_reg <= cfg_wdata[7:0];
                CFG_PRESET:   preset_reg   <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // Packet tracking on the accept side
    logic       in_packet_reg;
    logic       in_packet_next;
    logic [7:0] bytes_left_reg;
    logic [7:0] bytes_left_next;

    // Job register: one accepted transaction waiting to be serialized
    logic       job_valid_reg;
    logic       job_start_reg;
    logic       job_crc_reg;      // CRC bytes follow the data bytes
    step_t      step_reg;
    logic [7:0] job_src_reg;
    logic [7:0] job_dst_reg;
    logic [7:0] job_hdr_reg;
    logic [7:0] job_len_reg;      // length on start, payload byte otherwise

    logic       job_create;
    logic       job_add_crc;
    logic       accept;
    logic       emit;
    logic       job_done;

    // Output register
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;

    logic [7:0] emit_byte;
    logic [23:0] crc_val;
    crc_ctl_t   crc_ctl;

    // Advance when the output register is free or being drained this cycle
    assign emit     = job_valid_reg && (!m_tvalid_reg || m_tready);
    assign job_done = (step_reg == STEP_CRC_LO) || ((step_reg == STEP_LEN) && !job_crc_reg);
    assign s_tready = !job_valid_reg || (emit && job_done);
    assign accept   = s_tvalid && s_tready;

    // Decide what the accepted transaction produces
    always_comb begin
        in_packet_next  = in_packet_reg;
        bytes_left_next = bytes_left_reg;
        job_create      = 1'b0;
        job_add_crc     = 1'b0;
        priority if (!s_tuser) begin
            // start: drop any open packet and open a new one
            job_create      = 1'b1;
            job_add_crc     = (len_clamped == 8'd0);
            bytes_left_next = len_clamped;
            in_packet_next  = (len_clamped != 8'd0);
        end else if (in_packet_reg && (bytes_left_reg != 8'd0)) begin
            job_create      = 1'b1;
            bytes_left_next = bytes_left_reg - 8'd1;
            if (bytes_left_reg == 8'd1) begin
                job_add_crc    = 1'b1;
                in_packet_next = 1'b0;
            end
        end else begin
            // payload outside a packet: drop it
            job_create = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_packet_reg  <= 1'b0;
            bytes_left_reg <= 8'd0;
        end else if (accept) begin
            in_packet_reg  <= in_packet_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            job_start_reg <= 1'b0;
            job_crc_reg   <= 1'b0;
            step_reg      <= STEP_PREAMBLE;
        end else if (accept) begin
            job_valid_reg <= job_create;
            job_start_reg <= !s_tuser;
            job_crc_reg   <= job_add_crc;
            step_reg      <= s_tuser ? STEP_LEN : STEP_PREAMBLE;
        end else if (emit) begin
            if (job_done) begin
                job_valid_reg <= 1'b0;
            end else begin
                step_reg <= step_t'(step_reg + 3'd1);
            end
        end
    end

    // Job payload fields carry no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            job_src_reg <= in_src;
            job_dst_reg <= in_dst;
            job_hdr_reg <= in_hdr;
            job_len_reg <= s_tuser ? in_pay : len_clamped;
        end
    end

    // Select the byte for the current step
    always_comb begin
        unique case (step_reg)
            STEP_PREAMBLE: emit_byte = preamble_reg;
            STEP_SOURCE:   emit_byte = job_src_reg;
            STEP_DEST:     emit_byte = job_dst_reg;
            STEP_HEADER:   emit_byte = job_hdr_reg;
            STEP_LEN:      emit_byte = job_len_reg;
            STEP_CRC_HI:   emit_byte = crc_val[23:16];
            STEP_CRC_MID:  emit_byte = crc_val[15:8];
            STEP_CRC_LO:   emit_byte = crc_val[7:0];
            default:       emit_byte = 8'd0;
        endcase
    end

    // Feed every head and payload byte into the CRC as it is emitted
    assign crc_ctl.feed = emit && (step_reg <= STEP_LEN);
    assign crc_ctl.load = (step_reg == STEP_PREAMBLE);

    pfc_crc_unit u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (crc_ctl),
        .data    (emit_byte),
        .preset  (preset_reg),
        .crc     (crc_val)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= emit_byte;
            m_tlast_reg <= (step_reg == STEP_CRC_LO);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // An open packet always expects at least one more payload byte
    a_open_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        in_packet_reg |-> (bytes_left_reg != 8'd0))
        else $error("open packet with no bytes left");

    // A job without CRC never walks into the CRC steps
    a_no_crc_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_valid_reg && !job_crc_reg) |-> (step_reg <= STEP_LEN))
        else $error("CRC step reached on a job without CRC");

    // Payload jobs start at the data step, never in the head
    a_payload_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_valid_reg && !job_start_reg) |-> (step_reg >= STEP_LEN))
        else $error("payload job in head step");

    // Back pressure on the slave side only comes from an occupied job register
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> job_valid_reg)
        else $error("s_tready low with empty job register");

    // The last CRC byte is emitted only on a job that carries CRC bytes
    a_last_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && (step_reg == STEP_CRC_LO)) |-> job_crc_reg)
        else $error("last byte on a job without CRC");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for packet_framer_crc24: drives start and payload transactions,
// predicts every framed byte and its CRC-24 tail in a scoreboard class and checks the output.
// Depends on the packet_framer_crc24 RTL and its package only.
module testbench;

    localparam int          MAX_PAYLOAD    = 255;
    localparam logic [23:0] GEN_POLY       = 24'h00065B;
    localparam logic [23:0] PRESET_DEFAULT = 24'h555555;
    localparam int          REPORT_LIMIT   = 10;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          SETTLE_CYCLES  = 6;    // job register plus output register, with margin
    localparam int          DRAIN_CYCLES   = 20;

    // Register indexes of the configuration port
    localparam logic REG_PREAMBLE   = 1'b0;
    localparam logic REG_CRC_PRESET = 1'b1;

    // Transaction kind carried on s_tuser
    typedef enum logic {
        REQ_START   = 1'b0,
        REQ_PAYLOAD = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_last;
    } frame_byte_t;

    // Tracks the framer state and holds the bytes it still owes on the master channel
    class framer_scoreboard;
        frame_byte_t frame_bytes_due[$];
        logic [7:0]  preamble;
        logic [23:0] preset;
        logic [23:0] crc;
        logic [7:0]  remaining;
        bit          pkt_open;
        int          mismatches, unexpected, reported, checked;
        int          starts, payloads, strays, abandoned, packets;

        function new();
            preamble  = 8'h00;
            preset    = PRESET_DEFAULT;
            crc       = PRESET_DEFAULT;
            remaining = 8'h00;
            pkt_open  = 0;
        endfunction

        function void apply_config(logic idx, logic [23:0] val);
            if (idx == REG_PREAMBLE)
                preamble = val[7:0];
            else
                preset = val;
        endfunction

        // Clock one byte into the running CRC, top bit first
        function logic [23:0] crc_next(logic [23:0] c, logic [7:0] d);
            logic fb;
            for (int i = 0; i < 8; i++) begin
                fb = c[23] ^ d[7 - i];
                c  = {c[22:0], 1'b0} ^ (fb ? GEN_POLY : 24'h000000);
            end
            return c;
        endfunction

        function void emit(logic [7:0] b, logic fin, bit covered);
            frame_byte_t entry;
            entry.out_byte = b;
            entry.is_last  = fin;
            frame_bytes_due.push_back(entry);
            if (covered)
                crc = crc_next(crc, b);
        endfunction

        function void close_packet();
            emit(crc[23:16], 1'b0, 0);
            emit(crc[15:8],  1'b0, 0);
            emit(crc[7:0],   1'b1, 0);
            pkt_open  = 0;
            remaining = 8'h00;
            packets++;
        endfunction

        // Work out the bytes that one accepted input transaction produces
        function void frame_request(logic kind, logic [39:0] f);
            logic [7:0] len;
            if (kind == REQ_START) begin
                starts++;
                if (pkt_open)
                    abandoned++;
                len = f[31:24];
                if (len > MAX_PAYLOAD)
                    len = 8'(MAX_PAYLOAD);
                crc = preset;
                emit(preamble, 1'b0, 1);
                emit(f[7:0],   1'b0, 1);
                emit(f[15:8],  1'b0, 1);
                emit(f[23:16], 1'b0, 1);
                emit(len,      1'b0, 1);
                remaining = len;
                pkt_open  = 1;
                if (len == 8'h00)
                    close_packet();
            end else if (!pkt_open || remaining == 8'h00) begin
                strays++;
            end else begin
                payloads++;
                emit(f[39:32], 1'b0, 1);
                remaining--;
                if (remaining == 8'h00)
                    close_packet();
            end
        endfunction

        function void check_byte(logic [7:0] b, logic fin);
            frame_byte_t exp_byte;
            checked++;
            if (frame_bytes_due.size() == 0) begin
                unexpected++;
                if (reported < REPORT_LIMIT) begin
                    reported++;
                    $display("ERROR: unexpected byte %02h last %0b at %0t", b, fin, $realtime);
                end
                return;
            end
            exp_byte = frame_bytes_due.pop_front();
            if (exp_byte.out_byte !== b || exp_byte.is_last !== fin) begin
                mismatches++;
                if (reported < REPORT_LIMIT) begin
                    reported++;
                    $display("ERROR: byte %0d at %0t: out_byte exp %02h got %02h, %s %0b got %0b",
                             checked, $realtime, exp_byte.out_byte, b, "last exp",
                             exp_byte.is_last, fin);
                end
            end
        endfunction

        function int pending();
            return frame_bytes_due.size();
        endfunction

        function int failures();
            return mismatches + unexpected + frame_bytes_due.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // [7:0] source_addr, [15:8] dest_addr, [23:16] header_byte,
                             // [31:24] payload_len, [39:32] payload_byte
    logic        s_tuser;    // [0] req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [7:0] out_byte
    logic        m_tlast;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [23:0] cfg_wdata;

    framer_scoreboard sb;
    int items_sent;
    int idle_cycles;
    int rx_hold;     // long receiver hold-off requested by the stimulus, counted down below
    int rx_gap;
    bit idle_on;     // random bubbles on both channels; cleared for the final stretch

    packet_framer_crc24 #(.MAX_PAYLOAD(MAX_PAYLOAD)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Sample both channels on the rising edge; feed the scoreboard and run the watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.frame_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_byte(m_tdata, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("ERROR: no transaction for %0d cycles, %0d bytes still due",
                         WATCHDOG_LIMIT, sb.pending());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Receiver: a long hold-off when asked, otherwise short random stall bursts
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_tready = 1'b0;
                rx_hold--;
            end else if (rx_gap > 0) begin
                m_tready = 1'b0;
                rx_gap--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_tready = 1'b0;
                rx_gap   = $urandom_range(0, 5);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Offer one transaction from a falling edge and hold it until the handshake
    task automatic send_txn(input logic kind, input logic [39:0] fields);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = fields;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        @(negedge aclk);
    endtask

    // Unused fields carry random bits so every tdata bit toggles
    task automatic send_start(input logic [7:0] src, input logic [7:0] dst,
                              input logic [7:0] hdr, input logic [7:0] len);
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        send_txn(REQ_START, {junk, len, hdr, dst, src});
    endtask

    task automatic send_payload(input logic [7:0] b);
        logic [31:0] junk;
        junk = $urandom;
        send_txn(REQ_PAYLOAD, {b, junk});
    endtask

    // Start a packet of the given length with random head fields, then send some payload
    task automatic send_frame(input int len, input int sent);
        send_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), len[7:0]);
        for (int i = 0; i < sent; i++)
            send_payload(8'($urandom_range(0, 255)));
    endtask

    // Drop valid, wait for every due byte, then let the pipeline settle
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [23:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.apply_config(idx, val);
    endtask

    // Mostly complete packets; some stray payloads and some packets cut short by a new start
    task automatic run_phase(input int goal);
        int pick;
        int len;
        while (items_sent < goal) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 40)
                                                  : $urandom_range(0, 8);
                send_frame(len, len);
            end else if (pick < 8) begin
                repeat ($urandom_range(1, 3)) send_payload(8'($urandom_range(0, 255)));
            end else begin
                len = $urandom_range(0, MAX_PAYLOAD);
                send_frame(len, $urandom_range(0, 3));
            end
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = REQ_START;
        s_tdata     = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_PREAMBLE;
        cfg_wdata   = '0;
        items_sent  = 0;
        idle_cycles = 0;
        rx_hold     = 0;
        rx_gap      = 0;
        idle_on     = 1;
        sb = new();
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Reset values of the registers: empty payload gives head plus CRC at once
        send_start(8'h00, 8'hFF, 8'h00, 8'h00);
        // Payload with no open packet: accepted and dropped
        send_payload(8'hA5);
        send_start(8'hFF, 8'h00, 8'hFF, 8'h02);
        send_payload(8'h00);
        send_payload(8'hFF);
        // Longest length, abandoned by a new start after two bytes
        send_start(8'h3C, 8'hC3, 8'h81, 8'hFF);
        send_payload(8'h12);
        send_payload(8'h34);
        send_start(8'h01, 8'h80, 8'h7E, 8'h01);
        send_payload(8'h5A);

        wait_idle();
        write_reg(REG_PREAMBLE, 24'h0000FF);
        write_reg(REG_CRC_PRESET, 24'hFFFFFF);
        send_start(8'h55, 8'hAA, 8'h0F, 8'h03);
        send_payload(8'h80);
        send_payload(8'h01);
        send_payload(8'h7F);
        send_start(8'hF0, 8'h0F, 8'hC3, 8'h00);

        wait_idle();
        write_reg(REG_PREAMBLE, 24'h000000);
        write_reg(REG_CRC_PRESET, 24'h000000);
        send_start(8'hAA, 8'h55, 8'hF0, 8'h00);
        // Preset rewritten mid-packet: the open packet keeps its running CRC
        send_start(8'h96, 8'h69, 8'h3C, 8'h04);
        send_payload(8'hC3);
        send_payload(8'h3C);
        wait_idle();
        write_reg(REG_CRC_PRESET, 24'h123456);
        send_payload(8'hE7);
        send_payload(8'h18);

        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            write_reg(REG_PREAMBLE, 24'($urandom_range(0, 255)));
            write_reg(REG_CRC_PRESET, 24'($urandom_range(0, 24'hFFFFFF)));
            if (ph == 1) begin
                // Hold the receiver off while a long packet keeps coming: the input must stall
                rx_hold = 90;
                send_frame(24, 24);
            end
            if (ph == 3)
                idle_on = 0;
            run_phase(items_sent + 26);
        end

        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Sent %0d transactions: %0d starts (%0d cut short), %0d payload, %0d dropped",
                 items_sent, sb.starts, sb.abandoned, sb.payloads, sb.strays);
        $display("Closed %0d packets, checked %0d output bytes, %0d mismatched, %0d unexpected",
                 sb.packets, sb.checked, sb.mismatches, sb.unexpected);
        if (sb.failures() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/pfc_pkg.sv
rtl/pfc_crc_unit.sv
rtl/packet_framer_crc24.sv
sim/testbench.sv
